// File: hdl/gsr_pkg.sv
// ============================================================================
// gsr_pkg
// Shared types, codes and constants of the glyph search and row renderer.
// ============================================================================
package gsr_pkg;

  localparam int DEF_MAX_GLYPHS  = 8192;
  localparam int DEF_GLYPH_BYTES = 30;

  localparam int SLOT_W   = 13;
  localparam int BOFF_W   = 5;
  localparam int CODE_W   = 16;
  localparam int BYTE_W   = 8;
  localparam int POS_W    = 12;
  localparam int COLOR_W  = 8;
  localparam int PITCH_W  = 13;
  localparam int COUNT_W  = 14;
  localparam int ADDR_W   = 25;
  localparam int MASK_W   = 16;
  localparam int ROW_W    = 4;
  localparam int IDX_W    = 17;
  localparam int SLOTX_W  = 16;
  localparam int CMD_W    = 2;
  localparam int CFG_AW   = 1;
  localparam int CFG_DW   = 14;

  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 56;

  localparam logic [CMD_W-1:0] CMD_LOAD_CODE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_GLYPH = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DRAW       = 2'd2;

  localparam logic [CFG_AW-1:0] REG_ROW_PITCH   = 1'b0;
  localparam logic [CFG_AW-1:0] REG_GLYPH_COUNT = 1'b1;

  localparam logic [PITCH_W-1:0] PITCH_RESET = 13'd320;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 14'd0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SETUP,
    ST_FETCH,
    ST_EMIT
  } gsr_state_t;

  typedef struct packed {
    logic               start;
    logic [CODE_W-1:0]  code;
    logic [IDX_W-1:0]   limit;
  } gsr_srch_req_t;

  typedef struct packed {
    logic               done;
    logic               hit;
    logic [SLOTX_W-1:0] slot;
  } gsr_srch_res_t;

  function automatic logic [BYTE_W-1:0] reverse_byte(input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] r;
    for (int k = 0; k < BYTE_W; k++) begin
      r[k] = b[BYTE_W-1-k];
    end
    return r;
  endfunction

endpackage

// File: hdl/gsr_code_search.sv
// ============================================================================
// gsr_code_search
// Code table memory and the linear search engine, one slot per cycle.
// ============================================================================
module gsr_code_search import gsr_pkg::*; #(
  parameter int MAX_GLYPHS = DEF_MAX_GLYPHS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  logic [IDX_W-1:0]  wr_slot,
  input  logic [CODE_W-1:0] wr_code,
  input  gsr_srch_req_t     req,
  output gsr_srch_res_t     res
);

  localparam int IW = (MAX_GLYPHS > 1) ? $clog2(MAX_GLYPHS) : 1;

  logic [CODE_W-1:0] mem [MAX_GLYPHS];
  logic [CODE_W-1:0] rd_q;
  logic              rd_en;
  logic [IW-1:0]     rd_addr;

  logic              busy_r, busy_nxt;
  logic              pend_r, pend_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [IDX_W-1:0]  pidx_r, pidx_nxt;
  logic [IDX_W-1:0]  limit_r;
  logic [CODE_W-1:0] code_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_slot[IW-1:0]] <= wr_code;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pend_r <= 1'b0;
      idx_r  <= '0;
      pidx_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      pend_r <= pend_nxt;
      idx_r  <= idx_nxt;
      pidx_r <= pidx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      code_r  <= req.code;
      limit_r <= req.limit;
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    pend_nxt = pend_r;
    idx_nxt  = idx_r;
    pidx_nxt = pidx_r;
    rd_en    = 1'b0;
    rd_addr  = idx_r[IW-1:0];
    res.done = 1'b0;
    res.hit  = 1'b0;
    res.slot = pidx_r[SLOTX_W-1:0];
    if (req.start) begin
      busy_nxt = 1'b1;
      pend_nxt = 1'b0;
      idx_nxt  = '0;
    end else if (busy_r) begin
      if (pend_r && (rd_q == code_r)) begin
        res.done = 1'b1;
        res.hit  = 1'b1;
        busy_nxt = 1'b0;
        pend_nxt = 1'b0;
      end else if (idx_r < limit_r) begin
        rd_en    = 1'b1;
        pend_nxt = 1'b1;
        pidx_nxt = idx_r;
        idx_nxt  = idx_r + 1'b1;
      end else begin
        res.done = 1'b1;
        busy_nxt = 1'b0;
        pend_nxt = 1'b0;
      end
    end
  end

endmodule

// File: hdl/gsr_glyph_store.sv
// ============================================================================
// gsr_glyph_store
// Glyph bitmap memory, one 16-bit word per glyph row with byte-lane writes.
// ============================================================================
module gsr_glyph_store import gsr_pkg::*; #(
  parameter int DEPTH = DEF_MAX_GLYPHS * (DEF_GLYPH_BYTES / 2)
) (
  input  logic                                         clk,
  input  logic                                         wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic                                         wr_right,
  input  logic [BYTE_W-1:0]                            wr_byte,
  input  logic                                         rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [2*BYTE_W-1:0]                          rd_data
);

  logic [2*BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      if (wr_right) begin
        mem[wr_addr][2*BYTE_W-1:BYTE_W] <= wr_byte;
      end else begin
        mem[wr_addr][BYTE_W-1:0] <= wr_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hdl/glyph_search_and_row_render_top.sv
// ============================================================================
// glyph_search_and_row_render_top
// Character generator for 16x15 one-bit glyphs with a searched code table.
// ============================================================================
// Input words carry a command in in_tuser: load a code table entry, load one
// glyph byte, or draw a character. Loads emit nothing. A
// draw searches the code table from slot 0 up to the configured count, one
// slot per cycle through the table's single read port, and on a hit emits
// one output word per glyph row, top row first, with out_tlast on the final
// row. A miss emits nothing.
// A miss returns to idle once the search has passed the last slot; a hit moves
// to the SETUP state, which does the address multiply, and each row then
// passes through FETCH, the glyph store read, and EMIT, the output register
// load. Loads and draws are taken one at a time; in_tready is high only
// while no draw is in progress.
// The output register holds a word until it is taken; a stalled receiver
// pauses the row sequence and nothing is lost. Reset clears the control
// state and the registers (row pitch 320, glyph count 0); the memories are
// not cleared and must be loaded before use.
// ============================================================================
module glyph_search_and_row_render_top import gsr_pkg::*; #(
  parameter int MAX_GLYPHS  = DEF_MAX_GLYPHS,
  parameter int GLYPH_BYTES = DEF_GLYPH_BYTES
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_AW-1:0]      cfg_addr,
  input  logic [CFG_DW-1:0]      cfg_wdata,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // slot[12:0], byte_offset[17:13], char_code[33:18], glyph_byte[41:34],
  // pos_x[53:42], pos_y[65:54], color[73:66], zero fill[79:74]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // cmd[1:0]
  input  logic [CMD_W-1:0]       in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // row_address[24:0], pixel_mask[40:25], pixel_color[48:41],
  // glyph_row[52:49], zero fill[55:53]
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast
);

  localparam int NUM_ROWS = ((GLYPH_BYTES / 2) > 15) ? 15 : (GLYPH_BYTES / 2);
  localparam int G_DEPTH  = MAX_GLYPHS * NUM_ROWS;
  localparam int G_AW     = (G_DEPTH > 1) ? $clog2(G_DEPTH) : 1;
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(NUM_ROWS - 1);
  localparam logic [IDX_W-1:0] MAX_IDX  = IDX_W'(MAX_GLYPHS);

  logic [SLOT_W-1:0]  in_slot;
  logic [BOFF_W-1:0]  in_boff;
  logic [CODE_W-1:0]  in_code;
  logic [BYTE_W-1:0]  in_byte;
  logic [POS_W-1:0]   in_x;
  logic [POS_W-1:0]   in_y;
  logic [COLOR_W-1:0] in_color;
  logic [IDX_W-1:0]   in_slot_ext;

  assign in_slot     = in_tdata[12:0];
  assign in_boff     = in_tdata[17:13];
  assign in_code     = in_tdata[33:18];
  assign in_byte     = in_tdata[41:34];
  assign in_x        = in_tdata[53:42];
  assign in_y        = in_tdata[65:54];
  assign in_color    = in_tdata[73:66];
  assign in_slot_ext = {{(IDX_W - SLOT_W){1'b0}}, in_slot};

  logic [PITCH_W-1:0] pitch_r;
  logic [COUNT_W-1:0] count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pitch_r <= PITCH_RESET;
      count_r <= COUNT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_ROW_PITCH:   pitch_r <= cfg_wdata[PITCH_W-1:0];
        REG_GLYPH_COUNT: count_r <= cfg_wdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  gsr_state_t         state_r, state_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic [ADDR_W-1:0]  addr_r, addr_nxt;
  logic [G_AW-1:0]    gbase_r, gbase_nxt;
  logic [POS_W-1:0]   x_r, y_r;
  logic [COLOR_W-1:0] color_r;
  logic [SLOTX_W-1:0] slot_r, slot_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0]  out_addr_r, out_addr_nxt;
  logic [MASK_W-1:0]  out_mask_r, out_mask_nxt;
  logic [COLOR_W-1:0] out_color_r, out_color_nxt;
  logic [ROW_W-1:0]   out_row_r, out_row_nxt;
  logic               out_last_r, out_last_nxt;

  logic               in_fire;
  logic               slot_ok;
  logic [IDX_W-1:0]   count_ext;
  gsr_srch_req_t      srch_req;
  gsr_srch_res_t      srch_res;
  logic               code_we;
  logic               glyph_we;
  logic [G_AW-1:0]    glyph_waddr;
  logic               glyph_re;
  logic [G_AW-1:0]    glyph_raddr;
  logic [2*BYTE_W-1:0] glyph_rdata;

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign slot_ok   = (in_slot_ext < MAX_IDX);
  assign count_ext = {{(IDX_W - COUNT_W){1'b0}}, count_r};

  assign code_we     = in_fire && (in_tuser == CMD_LOAD_CODE) && slot_ok;
  assign glyph_we    = in_fire && (in_tuser == CMD_LOAD_GLYPH) && slot_ok &&
                       (int'(in_boff) < GLYPH_BYTES) && (int'(in_boff[4:1]) < NUM_ROWS);
  assign glyph_waddr = G_AW'(int'(in_slot_ext) * NUM_ROWS + int'(in_boff[4:1]));

  assign srch_req.start = in_fire && (in_tuser == CMD_DRAW);
  assign srch_req.code  = in_code;
  assign srch_req.limit = (count_ext < MAX_IDX) ? count_ext : MAX_IDX;

  gsr_code_search #(
    .MAX_GLYPHS(MAX_GLYPHS)
  ) u_search (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (code_we),
    .wr_slot(in_slot_ext),
    .wr_code(in_code),
    .req    (srch_req),
    .res    (srch_res)
  );

  gsr_glyph_store #(
    .DEPTH(G_DEPTH)
  ) u_glyphs (
    .clk     (clk),
    .wr_en   (glyph_we),
    .wr_addr (glyph_waddr),
    .wr_right(in_boff[0]),
    .wr_byte (in_byte),
    .rd_en   (glyph_re),
    .rd_addr (glyph_raddr),
    .rd_data (glyph_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      row_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_r       <= row_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r      <= addr_nxt;
    gbase_r     <= gbase_nxt;
    slot_r      <= slot_nxt;
    out_addr_r  <= out_addr_nxt;
    out_mask_r  <= out_mask_nxt;
    out_color_r <= out_color_nxt;
    out_row_r   <= out_row_nxt;
    out_last_r  <= out_last_nxt;
    if (srch_req.start) begin
      x_r     <= in_x;
      y_r     <= in_y;
      color_r <= in_color;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    row_nxt       = row_r;
    addr_nxt      = addr_r;
    gbase_nxt     = gbase_r;
    slot_nxt      = slot_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_addr_nxt  = out_addr_r;
    out_mask_nxt  = out_mask_r;
    out_color_nxt = out_color_r;
    out_row_nxt   = out_row_r;
    out_last_nxt  = out_last_r;
    glyph_re      = 1'b0;
    glyph_raddr   = gbase_r + G_AW'(row_r);
    unique case (state_r)
      ST_IDLE: begin
        if (srch_req.start) begin
          state_nxt = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (srch_res.done) begin
          slot_nxt  = srch_res.slot;
          state_nxt = srch_res.hit ? ST_SETUP : ST_IDLE;
        end
      end
      ST_SETUP: begin
        addr_nxt  = ADDR_W'(y_r * pitch_r + {{(ADDR_W - POS_W){1'b0}}, x_r});
        gbase_nxt = G_AW'(int'(slot_r) * NUM_ROWS);
        row_nxt   = '0;
        state_nxt = ST_FETCH;
      end
      ST_FETCH: begin
        glyph_re  = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_addr_nxt  = addr_r;
          out_mask_nxt  = {reverse_byte(glyph_rdata[2*BYTE_W-1:BYTE_W]),
                           reverse_byte(glyph_rdata[BYTE_W-1:0])};
          out_color_nxt = color_r;
          out_row_nxt   = row_r;
          out_last_nxt  = (row_r == LAST_ROW);
          addr_nxt      = addr_r + {{(ADDR_W - PITCH_W){1'b0}}, pitch_r};
          row_nxt       = row_r + 1'b1;
          state_nxt     = (row_r == LAST_ROW) ? ST_IDLE : ST_FETCH;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{(OUT_TDATA_W - ADDR_W - MASK_W - COLOR_W - ROW_W){1'b0}},
                       out_row_r, out_color_r, out_mask_r, out_addr_r};

  a_last_on_final_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_last_r == (out_row_r == LAST_ROW)))
    else $error("tlast does not match the final glyph row");

  a_hit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEARCH && srch_res.done && srch_res.hit) |->
      ({1'b0, srch_res.slot} < srch_req.limit || {1'b0, srch_res.slot} < MAX_IDX))
    else $error("search hit reported beyond the table");

  a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FETCH || state_r == ST_EMIT) |-> (int'(row_r) < NUM_ROWS))
    else $error("row counter ran past the glyph height");

  a_miss_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEARCH && srch_res.done && !srch_res.hit) |=> in_tready)
    else $error("a missed search did not return to idle");

endmodule

// File: tb/glyph_search_and_row_render_top_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// glyph_search_and_row_render_top_tb
// Self-checking bench for the glyph search and row renderer. It loads code
// and glyph tables, draws characters and predicts every row word. The run
// goes through several pitch and count settings and idle patterns. Draws are
// only sent when their search stays inside written table entries.
// ============================================================================
module glyph_search_and_row_render_top_tb;
  import gsr_pkg::*;

  localparam int IN_FILL_W = IN_TDATA_W - SLOT_W - BOFF_W - CODE_W - BYTE_W - 2 * POS_W
                             - COLOR_W;
  localparam int OUT_FILL_W = OUT_TDATA_W - ADDR_W - MASK_W - COLOR_W - ROW_W;
  localparam int GLYPH_ROWS = (DEF_GLYPH_BYTES / 2 > 15) ? 15 : DEF_GLYPH_BYTES / 2;
  localparam int CYCLE_LIMIT = 1000000;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [IN_FILL_W-1:0] fill;
    logic [COLOR_W-1:0]   color;
    logic [POS_W-1:0]     pos_y;
    logic [POS_W-1:0]     pos_x;
    logic [BYTE_W-1:0]    glyph_byte;
    logic [CODE_W-1:0]    char_code;
    logic [BOFF_W-1:0]    byte_offset;
    logic [SLOT_W-1:0]    slot;
  } in_word_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    in_word_t         word;
  } glyph_cmd_t;

  typedef struct packed {
    logic [OUT_FILL_W-1:0] fill;
    logic [ROW_W-1:0]      row;
    logic [COLOR_W-1:0]    color;
    logic [MASK_W-1:0]     mask;
    logic [ADDR_W-1:0]     addr;
  } out_word_t;

  typedef struct packed {
    out_word_t word;
    logic      last;
  } row_due_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [CFG_AW-1:0]      cfg_addr = '0;
  logic [CFG_DW-1:0]      cfg_wdata = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [CMD_W-1:0]       in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;

  glyph_search_and_row_render_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Tables as the block should hold them, updated as words are accepted.
  bit [CODE_W-1:0]  code_mem [0:DEF_MAX_GLYPHS-1];
  bit [BYTE_W-1:0]  glyph_mem [0:DEF_MAX_GLYPHS*DEF_GLYPH_BYTES-1];
  logic [PITCH_W-1:0] pitch_setting = PITCH_RESET;
  logic [COUNT_W-1:0] count_setting = COUNT_RESET;

  // What has been queued so far, used to keep every draw inside written entries.
  bit [CODE_W-1:0]          shadow_code [0:DEF_MAX_GLYPHS-1];
  bit                       shadow_code_set [0:DEF_MAX_GLYPHS-1];
  bit [DEF_GLYPH_BYTES-1:0] shadow_bytes_set [0:DEF_MAX_GLYPHS-1];
  int unsigned              next_slot = 0;

  glyph_cmd_t  pending_cmds[$];
  row_due_t    rows_due[$];
  glyph_cmd_t  offered;
  glyph_cmd_t  next_cmd;
  out_word_t   seen_word;
  row_due_t    oldest_row;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  function automatic void predict_rows(input glyph_cmd_t c);
    int unsigned lim;
    int unsigned hit;
    int unsigned base;
    bit          found;
    bit [31:0]   prod;
    logic [ADDR_W-1:0] row_addr;
    bit [BYTE_W-1:0] left_rev;
    bit [BYTE_W-1:0] right_rev;
    row_due_t    d;
    case (c.cmd)
      CMD_LOAD_CODE: begin
        code_mem[c.word.slot] = c.word.char_code;
      end
      CMD_LOAD_GLYPH: begin
        if (c.word.byte_offset < DEF_GLYPH_BYTES)
          glyph_mem[c.word.slot * DEF_GLYPH_BYTES + c.word.byte_offset] = c.word.glyph_byte;
      end
      CMD_DRAW: begin
        lim = (count_setting < DEF_MAX_GLYPHS) ? count_setting : DEF_MAX_GLYPHS;
        found = 1'b0;
        hit = 0;
        while (!found && hit < lim) begin
          if (code_mem[hit] == c.word.char_code) found = 1'b1;
          else hit++;
        end
        if (found) begin
          base = hit * DEF_GLYPH_BYTES;
          prod = c.word.pos_y;
          prod = prod * pitch_setting + c.word.pos_x;
          row_addr = prod[ADDR_W-1:0];
          for (int r = 0; r < GLYPH_ROWS; r++) begin
            left_rev = {<<{glyph_mem[base + 2 * r]}};
            right_rev = {<<{glyph_mem[base + 2 * r + 1]}};
            d.word.fill = '0;
            d.word.row = ROW_W'(r);
            d.word.color = c.word.color;
            d.word.mask = {right_rev, left_rev};
            d.word.addr = row_addr;
            d.last = (r == GLYPH_ROWS - 1);
            rows_due.push_back(d);
            row_addr = row_addr + pitch_setting;
          end
        end
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) predict_rows(offered);
      if (!in_tvalid || in_tready) begin
        if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_cmd = pending_cmds.pop_front();
          offered <= next_cmd;
          in_tvalid <= 1'b1;
          in_tdata <= next_cmd.word;
          in_tuser <= next_cmd.cmd;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        seen_word = out_word_t'(out_tdata);
        if (rows_due.size() == 0) begin
          report_mismatch($sformatf("row word %h with no row due", out_tdata));
        end else begin
          oldest_row = rows_due.pop_front();
          if (seen_word.addr !== oldest_row.word.addr)
            report_mismatch($sformatf("row_address %h, expected %h",
                                      seen_word.addr, oldest_row.word.addr));
          if (seen_word.mask !== oldest_row.word.mask)
            report_mismatch($sformatf("pixel_mask %h, expected %h",
                                      seen_word.mask, oldest_row.word.mask));
          if (seen_word.color !== oldest_row.word.color)
            report_mismatch($sformatf("pixel_color %h, expected %h",
                                      seen_word.color, oldest_row.word.color));
          if (seen_word.row !== oldest_row.word.row)
            report_mismatch($sformatf("glyph_row %0d, expected %0d",
                                      seen_word.row, oldest_row.word.row));
          if (out_tlast !== oldest_row.last)
            report_mismatch($sformatf("last %b, expected %b on row %0d",
                                      out_tlast, oldest_row.last, oldest_row.word.row));
        end
      end
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  function automatic in_word_t random_word();
    in_word_t w;
    w.fill = '0;
    w.color = COLOR_W'($urandom);
    w.pos_y = POS_W'($urandom);
    w.pos_x = POS_W'($urandom);
    w.glyph_byte = BYTE_W'($urandom);
    w.char_code = CODE_W'($urandom);
    w.byte_offset = BOFF_W'($urandom);
    w.slot = SLOT_W'($urandom);
    return w;
  endfunction

  // A draw may only read code entries and glyphs that have been written.
  function automatic bit search_is_safe(input logic [CODE_W-1:0] code);
    int unsigned lim;
    lim = (count_setting < DEF_MAX_GLYPHS) ? count_setting : DEF_MAX_GLYPHS;
    for (int unsigned s = 0; s < lim; s++) begin
      if (!shadow_code_set[s]) return 1'b0;
      if (shadow_code[s] == code) return &shadow_bytes_set[s];
    end
    return 1'b1;
  endfunction

  task automatic queue_cmd(input logic [CMD_W-1:0] cmd, input in_word_t w);
    glyph_cmd_t c;
    c.cmd = cmd;
    c.word = w;
    if (cmd == CMD_LOAD_CODE) begin
      shadow_code[w.slot] = w.char_code;
      shadow_code_set[w.slot] = 1'b1;
    end else if (cmd == CMD_LOAD_GLYPH && w.byte_offset < DEF_GLYPH_BYTES) begin
      shadow_bytes_set[w.slot][w.byte_offset] = 1'b1;
    end
    pending_cmds.push_back(c);
  endtask

  task automatic queue_draw(input logic [CODE_W-1:0] code, input in_word_t w);
    w.char_code = code;
    if (search_is_safe(code)) queue_cmd(CMD_DRAW, w);
  endtask

  task automatic draw_at(input logic [CODE_W-1:0] code, input int unsigned x,
                         input int unsigned y, input int unsigned color);
    in_word_t w;
    w = random_word();
    w.pos_x = POS_W'(x);
    w.pos_y = POS_W'(y);
    w.color = COLOR_W'(color);
    queue_draw(code, w);
  endtask

  task automatic load_code(input int unsigned slot, input logic [CODE_W-1:0] code);
    in_word_t w;
    w = random_word();
    w.slot = SLOT_W'(slot);
    w.char_code = code;
    queue_cmd(CMD_LOAD_CODE, w);
  endtask

  task automatic load_glyph(input int unsigned slot, input logic [CODE_W-1:0] code);
    in_word_t    w;
    int unsigned kind;
    kind = 0;
    w = random_word();
    w.slot = SLOT_W'(slot);
    w.char_code = code;
    queue_cmd(CMD_LOAD_CODE, w);
    for (int b = 0; b < DEF_GLYPH_BYTES; b++) begin
      if (b % 2 == 0) kind = $urandom_range(3);
      w = random_word();
      w.slot = SLOT_W'(slot);
      w.byte_offset = BOFF_W'(b);
      if (kind == 0) w.glyph_byte = '0;
      else if (kind == 1) w.glyph_byte = '1;
      queue_cmd(CMD_LOAD_GLYPH, w);
    end
  endtask

  task automatic load_unused_bytes(input int unsigned slot);
    in_word_t w;
    for (int b = DEF_GLYPH_BYTES; b < 32; b++) begin
      w = random_word();
      w.slot = SLOT_W'(slot);
      w.byte_offset = BOFF_W'(b);
      queue_cmd(CMD_LOAD_GLYPH, w);
    end
  endtask

  task automatic random_actions(input int unsigned n);
    int unsigned pick;
    int unsigned s;
    int unsigned r;
    in_word_t    w;
    for (int unsigned i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      s = $urandom_range(next_slot - 1);
      w = random_word();
      if (pick < 40) begin
        queue_draw(shadow_code[s], w);
      end else if (pick < 50) begin
        queue_draw(w.char_code, w);
      end else if (pick < 62) begin
        r = $urandom_range(GLYPH_ROWS - 1);
        w.slot = SLOT_W'(s);
        w.byte_offset = BOFF_W'(2 * r);
        queue_cmd(CMD_LOAD_GLYPH, w);
        w = random_word();
        w.slot = SLOT_W'(s);
        w.byte_offset = BOFF_W'(2 * r + 1);
        queue_cmd(CMD_LOAD_GLYPH, w);
      end else if (pick < 70) begin
        w.slot = SLOT_W'(s);
        if ($urandom_range(1) == 1) w.char_code = shadow_code[$urandom_range(next_slot - 1)];
        queue_cmd(CMD_LOAD_CODE, w);
      end else if (pick < 75) begin
        if (next_slot < 64) begin
          w.slot = SLOT_W'(next_slot);
          queue_cmd(CMD_LOAD_CODE, w);
          next_slot++;
        end
      end else if (pick < 83) begin
        w.slot = SLOT_W'(s);
        w.byte_offset = BOFF_W'($urandom_range(31, DEF_GLYPH_BYTES));
        queue_cmd(CMD_LOAD_GLYPH, w);
      end else if (pick < 88) begin
        queue_cmd(CMD_UNUSED, w);
      end else begin
        queue_cmd(($urandom_range(1) == 1) ? CMD_LOAD_GLYPH : CMD_LOAD_CODE, w);
      end
    end
  endtask

  task automatic write_reg(input logic [CFG_AW-1:0] idx, input int unsigned value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= CFG_DW'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_ROW_PITCH) pitch_setting = PITCH_W'(value);
    else count_setting = COUNT_W'(value);
  endtask

  task automatic set_pace(input int unsigned send_pct, input int unsigned stall_pct);
    send_idle_pct = send_pct;
    recv_stall_pct = stall_pct;
  endtask

  // A draw that misses leaves no word behind, so the search time is waited out.
  task automatic wait_drained();
    while (pending_cmds.size() != 0 || in_tvalid || rows_due.size() != 0 || !in_tready)
      @(posedge clk);
    repeat (40 + ((count_setting < DEF_MAX_GLYPHS) ? count_setting : DEF_MAX_GLYPHS))
      @(posedge clk);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    set_pace(0, 0);
    draw_at(16'h0000, 1, 2, 3);
    queue_cmd(CMD_UNUSED, random_word());
    load_glyph(0, 16'h0000);
    load_glyph(1, 16'hFFFF);
    load_code(2, 16'h1234);
    load_code(3, 16'hFFFF);
    next_slot = 4;
    load_unused_bytes(0);
    load_unused_bytes(DEF_MAX_GLYPHS - 1);
    draw_at(16'hFFFF, 4095, 4095, 255);
    wait_drained();

    write_reg(REG_ROW_PITCH, 16383);
    write_reg(REG_GLYPH_COUNT, 4);
    draw_at(16'h0000, 0, 0, 0);
    draw_at(16'hFFFF, 4095, 4095, 255);
    draw_at(16'h0000, 4095, 0, 8'h5A);
    draw_at(16'hBEEF, 0, 4095, 255);
    queue_cmd(CMD_UNUSED, random_word());
    wait_drained();

    set_pace(72, 0);
    write_reg(REG_ROW_PITCH, 0);
    write_reg(REG_GLYPH_COUNT, 16383);
    draw_at(16'hFFFF, 100, 200, 7);
    random_actions(10);
    wait_drained();

    set_pace(0, 72);
    write_reg(REG_ROW_PITCH, $urandom_range(4096, 1));
    write_reg(REG_GLYPH_COUNT, $urandom_range(next_slot, 1));
    random_actions(10);
    wait_drained();

    set_pace(9, 9);
    write_reg(REG_ROW_PITCH, 4096);
    write_reg(REG_GLYPH_COUNT, next_slot + 2);
    random_actions(10);
    wait_drained();

    write_reg(REG_ROW_PITCH, 1);
    write_reg(REG_GLYPH_COUNT, DEF_MAX_GLYPHS);
    draw_at(16'h0000, 4095, 4095, 255);
    draw_at(shadow_code[next_slot - 1], 4095, 4095, 255);
    wait_drained();

    write_reg(REG_ROW_PITCH, 320);
    write_reg(REG_GLYPH_COUNT, 16383);
    draw_at(16'h0000, 17, 33, 1);
    draw_at(16'hFFFF, 4095, 4095, 128);
    wait_drained();

    if (mismatch_count == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

endmodule
